[sv/assert_macros.svh]
// assertion macros used by the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked in the same cycle
`define SAT_ASSERT_SAME(label, ante, cons, msg) \
   `SAT_ASSERT(label, (ante) |-> (cons), msg)

// implication checked in the next cycle
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
   `SAT_ASSERT(label, (ante) |=> (cons), msg)

`endif

[sv/sat_pkg.sv]
// types, constants and helpers of the shell argument tokenizer
package sat_pkg;

   localparam int MaxLineDefault = 4096;
   localparam int MaxArgsDefault = 255;

   localparam int PosWidth   = 13;
   localparam int CountWidth = 8;
   localparam int PosLimit   = 8191;
   localparam int ArgLimit   = 255;

   localparam logic [7:0] CharSep    = 8'd32;
   localparam logic [7:0] CharNul    = 8'd0;
   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharDquote = 8'h22;
   localparam logic [7:0] CharSquote = 8'h27;

   typedef enum logic [2:0] {
      KIND_BYTE      = 3'd0,
      KIND_END       = 3'd1,
      KIND_DONE      = 3'd2,
      KIND_EMPTY     = 3'd3,
      KIND_UNTERM_DQ = 3'd4,
      KIND_UNTERM_SQ = 3'd5
   } kind_type;

   typedef enum logic [5:0] {
      MODE_BETWEEN = 6'b000001,
      MODE_ARG     = 6'b000010,
      MODE_ESC     = 6'b000100,
      MODE_DQ      = 6'b001000,
      MODE_DQ_ESC  = 6'b010000,
      MODE_SQ      = 6'b100000
   } mode_type;

   typedef struct packed {
      kind_type                kind;
      logic [7:0]              byte_out;
      logic [CountWidth-1:0]   arg_count;
      logic [PosWidth-1:0]     error_column;
      logic                    last;
   } result_type;

   function automatic result_type make_result(kind_type kind, logic [7:0] bval,
                                              logic [CountWidth-1:0] cnt,
                                              logic [PosWidth-1:0] col);
      result_type r;
      r.kind         = kind;
      r.byte_out     = bval;
      r.arg_count    = cnt;
      r.error_column = col;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

[sv/shell_argument_tokenizer.sv]
// shell argument tokenizer: splits a nul-terminated line into arguments
//
// req channel: one line byte per item on req_char_in, a zero byte ends the line.
// rsp channel: argument bytes, argument ends, then one final item per line:
//   done with the argument count, empty line, or an unterminated quote error
//   with the 1-based column of the opening quote. rsp_last marks the final
//   result that one byte causes; a byte gives zero, one or two results.
// csr channel: one bit, high_bytes_separate (reset 1); the user writes it
//   only while idle, which the block itself does not enforce.
// a byte is registered in the input register, then its results are written
//   to the output buffer once it has room, and rsp_valid shows from there.
// throughput: one byte per cycle while the receiver is ready and each byte
//   gives at most one result; a byte giving two results holds up the next byte.
// the output buffer holds two results; the input register moves on only
//   when the buffer drains, so a stalled receiver holds everything in place
//   and req_ready drops once the input register is full.
// reset clears the line state, the buffer and the input register, and sets
//   high_bytes_separate.
`include "assert_macros.svh"

module shell_argument_tokenizer #(
   parameter int MAX_LINE = sat_pkg::MaxLineDefault,
   parameter int MAX_ARGS = sat_pkg::MaxArgsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_out,
   output logic [7:0]  rsp_arg_count,
   output logic [12:0] rsp_error_column,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_high_bytes_separate
);

   localparam logic [sat_pkg::PosWidth-1:0] PosCap =
      sat_pkg::PosWidth'((MAX_LINE < sat_pkg::PosLimit) ? MAX_LINE : sat_pkg::PosLimit);
   localparam logic [sat_pkg::CountWidth-1:0] ArgCap =
      sat_pkg::CountWidth'((MAX_ARGS < sat_pkg::ArgLimit) ? MAX_ARGS : sat_pkg::ArgLimit);

   logic                              hbs_ff;
   logic                              in_valid_ff;
   logic [7:0]                        in_char_ff;
   sat_pkg::mode_type                 mode_ff, mode_in;
   logic                              line_start_ff, line_start_in;
   logic [sat_pkg::PosWidth-1:0]      position_ff, position_in;
   logic [sat_pkg::PosWidth-1:0]      quote_col_ff, quote_col_in;
   logic [sat_pkg::CountWidth-1:0]    total_ff, total_in;
   sat_pkg::result_type               out0_ff, out1_ff;
   logic [1:0]                        out_cnt_ff;

   sat_pkg::result_type               res_a, res_b;
   logic [1:0]                        n_res;
   logic [sat_pkg::PosWidth-1:0]      pos_next;
   logic                              is_sep;
   logic                              is_quote;
   logic                              pop;
   logic                              in_consume;

   assign csr_ready  = 1'b1;
   assign rsp_valid  = (out_cnt_ff != 2'd0);
   assign pop        = rsp_valid && rsp_ready;
   assign in_consume = in_valid_ff && ((out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && pop));
   assign req_ready  = !in_valid_ff || in_consume;

   assign rsp_kind         = out0_ff.kind;
   assign rsp_byte_out     = out0_ff.byte_out;
   assign rsp_arg_count    = out0_ff.arg_count;
   assign rsp_error_column = out0_ff.error_column;
   assign rsp_last         = out0_ff.last;

   // one byte through the splitter
   always_comb begin
      pos_next = (position_ff < PosCap) ? position_ff + 1'b1 : position_ff;
      is_sep   = (in_char_ff inside {[sat_pkg::CharNul:sat_pkg::CharSep]}) ||
                 (hbs_ff && in_char_ff[7]);
      is_quote = in_char_ff inside {sat_pkg::CharDquote, sat_pkg::CharSquote};

      mode_in       = mode_ff;
      line_start_in = 1'b0;
      position_in   = pos_next;
      quote_col_in  = quote_col_ff;
      total_in      = total_ff;
      n_res         = 2'd0;
      res_a = sat_pkg::make_result(sat_pkg::KIND_BYTE, in_char_ff, '0, '0);
      res_b = sat_pkg::make_result(sat_pkg::KIND_BYTE, in_char_ff, '0, '0);

      case (mode_ff)
         sat_pkg::MODE_ESC: begin
            if (in_char_ff == sat_pkg::CharNul) begin
               // trailing backslash dropped, argument closed
               res_a = sat_pkg::make_result(sat_pkg::KIND_END, '0, '0, '0);
               res_b = sat_pkg::make_result(sat_pkg::KIND_DONE, '0, total_ff, '0);
               n_res = 2'd2;
               mode_in       = sat_pkg::MODE_BETWEEN;
               line_start_in = 1'b1;
               position_in   = '0;
               quote_col_in  = '0;
               total_in      = '0;
            end else if (is_quote || is_sep) begin
               n_res   = 2'd1;
               mode_in = sat_pkg::MODE_ARG;
            end else begin
               res_a   = sat_pkg::make_result(sat_pkg::KIND_BYTE, sat_pkg::CharBslash, '0, '0);
               n_res   = 2'd2;
               mode_in = sat_pkg::MODE_ARG;
            end
         end
         sat_pkg::MODE_DQ: begin
            if (in_char_ff == sat_pkg::CharNul) begin
               res_a = sat_pkg::make_result(sat_pkg::KIND_UNTERM_DQ, '0, '0, quote_col_ff);
               n_res = 2'd1;
               mode_in       = sat_pkg::MODE_BETWEEN;
               line_start_in = 1'b1;
               position_in   = '0;
               quote_col_in  = '0;
               total_in      = '0;
            end else if (in_char_ff == sat_pkg::CharDquote) begin
               mode_in = sat_pkg::MODE_ARG;
            end else if (in_char_ff == sat_pkg::CharBslash) begin
               mode_in = sat_pkg::MODE_DQ_ESC;
            end else begin
               n_res = 2'd1;
            end
         end
         sat_pkg::MODE_DQ_ESC: begin
            if (in_char_ff == sat_pkg::CharNul) begin
               res_a = sat_pkg::make_result(sat_pkg::KIND_UNTERM_DQ, '0, '0, quote_col_ff);
               n_res = 2'd1;
               mode_in       = sat_pkg::MODE_BETWEEN;
               line_start_in = 1'b1;
               position_in   = '0;
               quote_col_in  = '0;
               total_in      = '0;
            end else if (in_char_ff == sat_pkg::CharDquote) begin
               n_res   = 2'd1;
               mode_in = sat_pkg::MODE_DQ;
            end else begin
               res_a   = sat_pkg::make_result(sat_pkg::KIND_BYTE, sat_pkg::CharBslash, '0, '0);
               n_res   = 2'd2;
               mode_in = sat_pkg::MODE_DQ;
            end
         end
         sat_pkg::MODE_SQ: begin
            if (in_char_ff == sat_pkg::CharNul) begin
               res_a = sat_pkg::make_result(sat_pkg::KIND_UNTERM_SQ, '0, '0, quote_col_ff);
               n_res = 2'd1;
               mode_in       = sat_pkg::MODE_BETWEEN;
               line_start_in = 1'b1;
               position_in   = '0;
               quote_col_in  = '0;
               total_in      = '0;
            end else if (in_char_ff == sat_pkg::CharSquote) begin
               mode_in = sat_pkg::MODE_ARG;
            end else begin
               n_res = 2'd1;
            end
         end
         default: begin
            // between arguments or inside one
            if (in_char_ff == sat_pkg::CharNul) begin
               if (mode_ff == sat_pkg::MODE_ARG) begin
                  res_a = sat_pkg::make_result(sat_pkg::KIND_END, '0, '0, '0);
                  res_b = sat_pkg::make_result(sat_pkg::KIND_DONE, '0, total_ff, '0);
                  n_res = 2'd2;
               end else if (line_start_ff) begin
                  res_a = sat_pkg::make_result(sat_pkg::KIND_EMPTY, '0, '0, '0);
                  n_res = 2'd1;
               end else begin
                  res_a = sat_pkg::make_result(sat_pkg::KIND_DONE, '0, total_ff, '0);
                  n_res = 2'd1;
               end
               mode_in       = sat_pkg::MODE_BETWEEN;
               line_start_in = 1'b1;
               position_in   = '0;
               quote_col_in  = '0;
               total_in      = '0;
            end else if (is_sep) begin
               if (mode_ff == sat_pkg::MODE_ARG) begin
                  res_a = sat_pkg::make_result(sat_pkg::KIND_END, '0, '0, '0);
                  n_res = 2'd1;
               end
               mode_in = sat_pkg::MODE_BETWEEN;
            end else begin
               if ((mode_ff != sat_pkg::MODE_ARG) && (total_ff < ArgCap)) begin
                  total_in = total_ff + 1'b1;
               end
               if (in_char_ff == sat_pkg::CharBslash) begin
                  mode_in = sat_pkg::MODE_ESC;
               end else if (in_char_ff == sat_pkg::CharDquote) begin
                  quote_col_in = pos_next;
                  mode_in      = sat_pkg::MODE_DQ;
               end else if (in_char_ff == sat_pkg::CharSquote) begin
                  quote_col_in = pos_next;
                  mode_in      = sat_pkg::MODE_SQ;
               end else begin
                  n_res   = 2'd1;
                  mode_in = sat_pkg::MODE_ARG;
               end
            end
         end
      endcase

      if (n_res == 2'd1) begin
         res_a.last = 1'b1;
      end
      if (n_res == 2'd2) begin
         res_b.last = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hbs_ff        <= 1'b1;
         in_valid_ff   <= 1'b0;
         mode_ff       <= sat_pkg::MODE_BETWEEN;
         line_start_ff <= 1'b1;
         position_ff   <= '0;
         quote_col_ff  <= '0;
         total_ff      <= '0;
         out_cnt_ff    <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            hbs_ff <= csr_high_bytes_separate;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (in_consume) begin
            mode_ff       <= mode_in;
            line_start_ff <= line_start_in;
            position_ff   <= position_in;
            quote_col_ff  <= quote_col_in;
            total_ff      <= total_in;
            out_cnt_ff    <= n_res;
         end else if (pop) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_in;
      end
      if (in_consume) begin
         out0_ff <= res_a;
         out1_ff <= res_b;
      end else if (pop) begin
         out0_ff <= out1_ff;
      end
   end

   `SAT_ASSERT_SAME(a_pair_head_not_last, out_cnt_ff == 2'd2, !out0_ff.last,
      "first of two buffered results is marked last")
   `SAT_ASSERT_NEXT(a_line_end_resets, in_consume && (in_char_ff == sat_pkg::CharNul),
      line_start_ff && (mode_ff == sat_pkg::MODE_BETWEEN) && (total_ff == '0),
      "line state not cleared after line end")
   `SAT_ASSERT_SAME(a_column_only_on_quote_error,
      rsp_valid && (rsp_kind != sat_pkg::KIND_UNTERM_DQ) &&
      (rsp_kind != sat_pkg::KIND_UNTERM_SQ),
      rsp_error_column == '0, "error column set on a non-quote result")
   `SAT_ASSERT_SAME(a_take_only_when_drained, in_consume,
      (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_ready),
      "item taken while results still buffered")

endmodule
